/* hdl/jbt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jbt_pkg: shared types and functions for the JSON byte tokenizer
// Token kinds, lexer modes, number state and the per-byte helper functions.
// ----------------------------------------------------------------------------
package jbt_pkg;

    localparam int MAX_MANTISSA_DIGITS = 18;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = 2;

    localparam logic [59:0] MANTISSA_LIMIT = 60'(64'd10 ** MAX_MANTISSA_DIGITS);

    localparam logic [3:0] KIND_LBRACKET = 4'd0;
    localparam logic [3:0] KIND_LBRACE   = 4'd1;
    localparam logic [3:0] KIND_RBRACKET = 4'd2;
    localparam logic [3:0] KIND_RBRACE   = 4'd3;
    localparam logic [3:0] KIND_COLON    = 4'd4;
    localparam logic [3:0] KIND_COMMA    = 4'd5;
    localparam logic [3:0] KIND_TRUE     = 4'd6;
    localparam logic [3:0] KIND_NUMBER   = 4'd9;
    localparam logic [3:0] KIND_SBYTE    = 4'd10;
    localparam logic [3:0] KIND_SEND     = 4'd11;
    localparam logic [3:0] KIND_ERROR    = 4'd12;

    localparam logic [3:0] MODE_IDLE    = 4'd0;
    localparam logic [3:0] MODE_LITERAL = 4'd1;
    localparam logic [3:0] MODE_STRING  = 4'd2;
    localparam logic [3:0] MODE_NSIGN   = 4'd3;
    localparam logic [3:0] MODE_NZERO   = 4'd4;
    localparam logic [3:0] MODE_NINT    = 4'd5;
    localparam logic [3:0] MODE_FSTART  = 4'd6;
    localparam logic [3:0] MODE_NFRAC   = 4'd7;
    localparam logic [3:0] MODE_ESTART  = 4'd8;
    localparam logic [3:0] MODE_ESIGN   = 4'd9;
    localparam logic [3:0] MODE_NEXP    = 4'd10;
    localparam logic [3:0] MODE_DROP    = 4'd11;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef struct packed {
        logic [59:0] mant;
        logic [4:0]  mcnt;
        logic [15:0] frac;
        logic [15:0] drop;
        logic [15:0] eacc;
        logic        eneg;
        logic        sneg;
        logic        inex;
    } num_t;

    typedef struct packed {
        logic [3:0] mode;
        logic [1:0] lsel;
        logic [2:0] lpos;
        num_t       num;
    } lex_state_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [7:0]         sbyte;
        logic               neg;
        logic [59:0]        mant;
        logic signed [15:0] expo;
        logic               inex;
        logic               done;
    } res_t;

    function automatic res_t tok_res(logic [3:0] kind, logic [7:0] sbyte);
        res_t r;
        r = '0;
        r.kind = kind;
        r.sbyte = sbyte;
        return r;
    endfunction

    function automatic res_t num_res(num_t n);
        res_t r;
        logic signed [17:0] e;
        logic inex;
        r = '0;
        inex = n.inex;
        e = $signed({2'b00, n.drop}) - $signed({2'b00, n.frac});
        if (n.eneg)
        begin
            e = e - $signed({2'b00, n.eacc});
        end
        else
        begin
            e = e + $signed({2'b00, n.eacc});
        end
        if (e > 18'sd32767)
        begin
            e = 18'sd32767;
            inex = 1'b1;
        end
        else if (e < -18'sd32768)
        begin
            e = -18'sd32768;
            inex = 1'b1;
        end
        r.kind = KIND_NUMBER;
        r.neg = n.sneg;
        r.mant = n.mant;
        r.expo = e[15:0];
        r.inex = inex;
        return r;
    endfunction

    function automatic logic [59:0] times_ten(logic [59:0] v, logic [3:0] d);
        return {v[56:0], 3'b000} + {v[58:0], 1'b0} + {56'd0, d};
    endfunction

    function automatic num_t int_digit(num_t s, logic [3:0] d);
        num_t r;
        r = s;
        if (!(s.mant == '0 && d == 4'd0))
        begin
            if (s.mcnt < 5'(MAX_MANTISSA_DIGITS))
            begin
                r.mant = times_ten(s.mant, d);
                r.mcnt = s.mcnt + 5'd1;
            end
            else
            begin
                // digit beyond the kept width only scales the value
                r.inex = 1'b1;
                if (s.drop != SAT16)
                begin
                    r.drop = s.drop + 16'd1;
                end
            end
        end
        return r;
    endfunction

    function automatic num_t frac_digit(num_t s, logic [3:0] d);
        num_t r;
        logic keep;
        r = s;
        keep = (s.mant == '0 && d == 4'd0);
        if (!keep && s.mcnt < 5'(MAX_MANTISSA_DIGITS))
        begin
            r.mant = times_ten(s.mant, d);
            r.mcnt = s.mcnt + 5'd1;
            keep = 1'b1;
        end
        if (keep)
        begin
            if (s.frac == SAT16)
            begin
                r.inex = 1'b1;
            end
            else
            begin
                r.frac = s.frac + 16'd1;
            end
        end
        else
        begin
            r.inex = 1'b1;
        end
        return r;
    endfunction

    function automatic num_t exp_digit(num_t s, logic [3:0] d);
        num_t r;
        logic [19:0] v;
        r = s;
        v = {1'b0, s.eacc, 3'b000} + {3'b000, s.eacc, 1'b0} + {16'd0, d};
        if (v > 20'h0FFFF)
        begin
            r.eacc = SAT16;
            r.inex = 1'b1;
        end
        else
        begin
            r.eacc = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] lit_char(logic [1:0] s, logic [2:0] p);
        logic [7:0] c;
        case ({s, p})
            {LIT_TRUE, 3'd0}:  c = "t";
            {LIT_TRUE, 3'd1}:  c = "r";
            {LIT_TRUE, 3'd2}:  c = "u";
            {LIT_TRUE, 3'd3}:  c = "e";
            {LIT_FALSE, 3'd0}: c = "f";
            {LIT_FALSE, 3'd1}: c = "a";
            {LIT_FALSE, 3'd2}: c = "l";
            {LIT_FALSE, 3'd3}: c = "s";
            {LIT_FALSE, 3'd4}: c = "e";
            {LIT_NULL, 3'd0}:  c = "n";
            {LIT_NULL, 3'd1}:  c = "u";
            {LIT_NULL, 3'd2}:  c = "l";
            {LIT_NULL, 3'd3}:  c = "l";
            default:           c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic lex_state_t start_token(input logic [7:0] b, input lex_state_t s,
                                               output logic emit, output logic [3:0] kind);
        lex_state_t r;
        r = s;
        r.mode = MODE_IDLE;
        emit = 1'b0;
        kind = KIND_ERROR;
        case (b) inside
            8'h20, 8'h09, 8'h0A, 8'h0D:
            begin
                emit = 1'b0;
            end
            "[":
            begin
                emit = 1'b1;
                kind = KIND_LBRACKET;
            end
            "{":
            begin
                emit = 1'b1;
                kind = KIND_LBRACE;
            end
            "]":
            begin
                emit = 1'b1;
                kind = KIND_RBRACKET;
            end
            "}":
            begin
                emit = 1'b1;
                kind = KIND_RBRACE;
            end
            ":":
            begin
                emit = 1'b1;
                kind = KIND_COLON;
            end
            ",":
            begin
                emit = 1'b1;
                kind = KIND_COMMA;
            end
            "t":
            begin
                r.lsel = LIT_TRUE;
                r.lpos = 3'd1;
                r.mode = MODE_LITERAL;
            end
            "f":
            begin
                r.lsel = LIT_FALSE;
                r.lpos = 3'd1;
                r.mode = MODE_LITERAL;
            end
            "n":
            begin
                r.lsel = LIT_NULL;
                r.lpos = 3'd1;
                r.mode = MODE_LITERAL;
            end
            "\"":
            begin
                r.mode = MODE_STRING;
            end
            "-":
            begin
                r.num = '0;
                r.num.sneg = 1'b1;
                r.mode = MODE_NSIGN;
            end
            "0":
            begin
                r.num = '0;
                r.mode = MODE_NZERO;
            end
            ["1":"9"]:
            begin
                r.num = int_digit('0, b[3:0]);
                r.mode = MODE_NINT;
            end
            default:
            begin
                emit = 1'b1;
                kind = KIND_ERROR;
                r.mode = MODE_DROP;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/jbt_lexer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jbt_lexer: lexer state and per-byte step
// Advances the lexer state by one byte and gives up to two result beats.
// ----------------------------------------------------------------------------
module jbt_lexer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    byte_in,
    input  wire logic          last,
    output jbt_pkg::res_t      res0,
    output jbt_pkg::res_t      res1,
    output logic [1:0]         res_cnt
);

    jbt_pkg::lex_state_t st_reg;
    jbt_pkg::lex_state_t st_next;
    jbt_pkg::lex_state_t cur;
    jbt_pkg::lex_state_t started;

    logic          dig;
    logic          ech;
    logic [3:0]    d;
    logic          st_emit;
    logic [3:0]    st_kind;
    logic [1:0]    s_idx;
    logic [2:0]    lit_len;
    logic [2:0]    p1;

    logic          a_v;
    logic          b_v;
    logic          c_v;
    jbt_pkg::res_t a_r;
    jbt_pkg::res_t b_r;
    jbt_pkg::res_t c_r;

    always_comb
    begin
        cur = st_reg;
        st_next = st_reg;
        dig = (byte_in >= "0") && (byte_in <= "9");
        ech = (byte_in == "e") || (byte_in == "E");
        d = byte_in[3:0];
        a_v = 1'b0;
        b_v = 1'b0;
        c_v = 1'b0;
        a_r = jbt_pkg::num_res(cur.num);
        b_r = jbt_pkg::tok_res(jbt_pkg::KIND_ERROR, 8'h00);
        c_r = jbt_pkg::tok_res(jbt_pkg::KIND_ERROR, 8'h00);
        st_emit = 1'b0;
        st_kind = jbt_pkg::KIND_ERROR;
        started = jbt_pkg::start_token(byte_in, cur, st_emit, st_kind);
        s_idx = (cur.lsel == 2'd3) ? jbt_pkg::LIT_TRUE : cur.lsel;
        lit_len = (s_idx == jbt_pkg::LIT_FALSE) ? 3'd5 : 3'd4;
        p1 = cur.lpos + 3'd1;

        case (cur.mode)
            jbt_pkg::MODE_IDLE:
            begin
                st_next = started;
                b_v = st_emit;
                b_r = jbt_pkg::tok_res(st_kind, 8'h00);
            end
            jbt_pkg::MODE_LITERAL:
            begin
                if (cur.lpos < lit_len && jbt_pkg::lit_char(s_idx, cur.lpos) == byte_in)
                begin
                    if (p1 >= lit_len)
                    begin
                        b_v = 1'b1;
                        b_r = jbt_pkg::tok_res(jbt_pkg::KIND_TRUE + {2'b00, s_idx}, 8'h00);
                        st_next.mode = jbt_pkg::MODE_IDLE;
                        st_next.lpos = 3'd0;
                    end
                    else
                    begin
                        st_next.lpos = p1;
                    end
                end
                else
                begin
                    b_v = 1'b1;
                    st_next.mode = jbt_pkg::MODE_DROP;
                end
            end
            jbt_pkg::MODE_STRING:
            begin
                b_v = 1'b1;
                if (byte_in == "\"")
                begin
                    b_r = jbt_pkg::tok_res(jbt_pkg::KIND_SEND, 8'h00);
                    st_next.mode = jbt_pkg::MODE_IDLE;
                end
                else
                begin
                    b_r = jbt_pkg::tok_res(jbt_pkg::KIND_SBYTE, byte_in);
                end
            end
            jbt_pkg::MODE_NSIGN:
            begin
                if (byte_in == "0")
                begin
                    st_next.mode = jbt_pkg::MODE_NZERO;
                end
                else if (dig)
                begin
                    st_next.num = jbt_pkg::int_digit(cur.num, d);
                    st_next.mode = jbt_pkg::MODE_NINT;
                end
                else
                begin
                    b_v = 1'b1;
                    st_next.mode = jbt_pkg::MODE_DROP;
                end
            end
            jbt_pkg::MODE_NZERO, jbt_pkg::MODE_NINT:
            begin
                if (dig && cur.mode == jbt_pkg::MODE_NINT)
                begin
                    st_next.num = jbt_pkg::int_digit(cur.num, d);
                end
                else if (byte_in == ".")
                begin
                    st_next.mode = jbt_pkg::MODE_FSTART;
                end
                else if (ech)
                begin
                    st_next.mode = jbt_pkg::MODE_ESTART;
                end
                else
                begin
                    // close the number, then treat the byte as a fresh token
                    a_v = 1'b1;
                    st_next = started;
                    b_v = st_emit;
                    b_r = jbt_pkg::tok_res(st_kind, 8'h00);
                end
            end
            jbt_pkg::MODE_FSTART:
            begin
                if (dig)
                begin
                    st_next.num = jbt_pkg::frac_digit(cur.num, d);
                    st_next.mode = jbt_pkg::MODE_NFRAC;
                end
                else
                begin
                    b_v = 1'b1;
                    st_next.mode = jbt_pkg::MODE_DROP;
                end
            end
            jbt_pkg::MODE_NFRAC:
            begin
                if (dig)
                begin
                    st_next.num = jbt_pkg::frac_digit(cur.num, d);
                end
                else if (ech)
                begin
                    st_next.mode = jbt_pkg::MODE_ESTART;
                end
                else
                begin
                    a_v = 1'b1;
                    st_next = started;
                    b_v = st_emit;
                    b_r = jbt_pkg::tok_res(st_kind, 8'h00);
                end
            end
            jbt_pkg::MODE_ESTART:
            begin
                if (byte_in == "+" || byte_in == "-")
                begin
                    st_next.num.eneg = (byte_in == "-");
                    st_next.mode = jbt_pkg::MODE_ESIGN;
                end
                else if (dig)
                begin
                    st_next.num = jbt_pkg::exp_digit(cur.num, d);
                    st_next.mode = jbt_pkg::MODE_NEXP;
                end
                else
                begin
                    b_v = 1'b1;
                    st_next.mode = jbt_pkg::MODE_DROP;
                end
            end
            jbt_pkg::MODE_ESIGN:
            begin
                if (dig)
                begin
                    st_next.num = jbt_pkg::exp_digit(cur.num, d);
                    st_next.mode = jbt_pkg::MODE_NEXP;
                end
                else
                begin
                    b_v = 1'b1;
                    st_next.mode = jbt_pkg::MODE_DROP;
                end
            end
            jbt_pkg::MODE_NEXP:
            begin
                if (dig)
                begin
                    st_next.num = jbt_pkg::exp_digit(cur.num, d);
                end
                else
                begin
                    a_v = 1'b1;
                    st_next = started;
                    b_v = st_emit;
                    b_r = jbt_pkg::tok_res(st_kind, 8'h00);
                end
            end
            default:
            begin
                // drop mode: swallow bytes until the end of the document
                st_next = st_reg;
            end
        endcase

        if (last)
        begin
            case (st_next.mode)
                jbt_pkg::MODE_NZERO, jbt_pkg::MODE_NINT,
                jbt_pkg::MODE_NFRAC, jbt_pkg::MODE_NEXP:
                begin
                    c_v = 1'b1;
                    c_r = jbt_pkg::num_res(st_next.num);
                end
                jbt_pkg::MODE_LITERAL, jbt_pkg::MODE_STRING, jbt_pkg::MODE_NSIGN,
                jbt_pkg::MODE_FSTART, jbt_pkg::MODE_ESTART, jbt_pkg::MODE_ESIGN:
                begin
                    c_v = 1'b1;
                end
                default:
                begin
                    c_v = 1'b0;
                end
            endcase
            st_next = '0;
            st_next.mode = jbt_pkg::MODE_IDLE;
        end

        res_cnt = {1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v};
        res0 = a_v ? a_r : (b_v ? b_r : c_r);
        res1 = a_v ? (b_v ? b_r : c_r) : c_r;
        if (last && res_cnt == 2'd2)
        begin
            res1.done = 1'b1;
        end
        else if (last && res_cnt == 2'd1)
        begin
            res0.done = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (step)
        begin
            st_reg <= st_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/jbt_result_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jbt_result_fifo: result queue
// Takes zero, one or two result beats per cycle and hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module jbt_result_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [1:0]    push_cnt,
    input  wire jbt_pkg::res_t push0,
    input  wire jbt_pkg::res_t push1,
    output logic               room,
    output logic               out_valid,
    input  wire logic          out_ready,
    output jbt_pkg::res_t      head
);

    jbt_pkg::res_t mem [jbt_pkg::FIFO_DEPTH];

    logic [jbt_pkg::FIFO_AW-1:0] wp_reg;
    logic [jbt_pkg::FIFO_AW-1:0] wp_next;
    logic [jbt_pkg::FIFO_AW-1:0] rp_reg;
    logic [jbt_pkg::FIFO_AW-1:0] rp_next;
    logic [jbt_pkg::FIFO_AW:0]   count_reg;
    logic [jbt_pkg::FIFO_AW:0]   count_next;
    logic [1:0]                  n_in;
    logic                        pop;

    assign n_in = push ? push_cnt : 2'd0;
    assign pop = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign head = mem[rp_reg];
    assign room = (count_reg <= (jbt_pkg::FIFO_AW+1)'(jbt_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wp_next = wp_reg + jbt_pkg::FIFO_AW'(n_in);
        rp_next = rp_reg + jbt_pkg::FIFO_AW'(pop);
        count_next = count_reg + (jbt_pkg::FIFO_AW+1)'(n_in)
                     - (jbt_pkg::FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_in != 2'd0)
        begin
            mem[wp_reg] <= push0;
        end
        if (n_in == 2'd2)
        begin
            mem[wp_reg + jbt_pkg::FIFO_AW'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/json_byte_tokenizer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// json_byte_tokenizer_core: streaming JSON tokenizer
// One byte in per beat, JSON tokens out as result beats.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry byte_value and end_of_input, one
// document byte per beat; end_of_input marks the last byte of a document.
// Output channel: out_valid/out_ready carry one token per beat. String text
// comes out one byte per beat followed by a string-end beat; numbers come
// out as sign, decimal mantissa and decimal exponent. document_done marks
// the last beat caused by an end-of-input byte.
// Path: an accepted byte waits in the input register, is lexed when the
// result queue has room, and its result beats are written into the queue
// at that edge; out_valid shows them once the queue count has updated.
// Throughput: one byte per cycle while the queue has room. A byte yields
// zero, one or two result beats and the output side drains one beat per
// cycle while out_ready is high, so the rate is set by the four-entry
// result queue: a new byte is lexed only while it holds two beats or fewer.
// Stall: when out_ready is low the queue fills, the input register holds
// its byte and in_ready drops; nothing is lost.
// Reset: rst_n clears the lexer to idle between tokens and empties the
// input register and the result queue.
// ----------------------------------------------------------------------------
module json_byte_tokenizer_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         byte_value,
    input  wire logic               end_of_input,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              token_kind,
    output logic [7:0]              string_byte,
    output logic                    number_negative,
    output logic [59:0]             number_mantissa,
    output logic signed [15:0]      number_exponent,
    output logic                    number_inexact,
    output logic                    document_done
);

    logic          in_vld_reg;
    logic          in_vld_next;
    logic [7:0]    byte_reg;
    logic          eoi_reg;
    logic          room;
    logic          proc;
    logic          accept;
    logic [1:0]    res_cnt;
    jbt_pkg::res_t res0;
    jbt_pkg::res_t res1;
    jbt_pkg::res_t head;

    assign proc = in_vld_reg && room;
    assign in_ready = !in_vld_reg || proc;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (proc)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_value;
            eoi_reg <= end_of_input;
        end
    end

    jbt_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (proc),
        .byte_in (byte_reg),
        .last    (eoi_reg),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    jbt_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (proc),
        .push_cnt  (res_cnt),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign token_kind = head.kind;
    assign string_byte = head.sbyte;
    assign number_negative = head.neg;
    assign number_mantissa = head.mant;
    assign number_exponent = head.expo;
    assign number_inexact = head.inex;
    assign document_done = head.done;

endmodule
`default_nettype wire

/* hdl/jbt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jbt_checker: port-level checks for the tokenizer
// Watches the result channel and flags beats that break the token format.
// ----------------------------------------------------------------------------
module jbt_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [3:0]         token_kind,
    input  wire logic [7:0]         string_byte,
    input  wire logic               number_negative,
    input  wire logic [59:0]        number_mantissa,
    input  wire logic signed [15:0] number_exponent,
    input  wire logic               number_inexact,
    input  wire logic               document_done
);

    // a stalled beat must hold
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind)
            && $stable(number_mantissa) && $stable(string_byte) && $stable(document_done))
    else $error("stalled result beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != jbt_pkg::KIND_NUMBER |->
            number_mantissa == '0 && number_exponent == '0
            && !number_negative && !number_inexact)
    else $error("number fields set on a non-number token");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != jbt_pkg::KIND_SBYTE |-> string_byte == 8'h00)
    else $error("string byte set on a non-string token");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == jbt_pkg::KIND_NUMBER |->
            number_mantissa < jbt_pkg::MANTISSA_LIMIT)
    else $error("mantissa holds more digits than kept");

endmodule

bind json_byte_tokenizer_core jbt_checker u_jbt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .token_kind      (token_kind),
    .string_byte     (string_byte),
    .number_negative (number_negative),
    .number_mantissa (number_mantissa),
    .number_exponent (number_exponent),
    .number_inexact  (number_inexact),
    .document_done   (document_done)
);
`default_nettype wire
